FILE: hdl/adsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adsf_pkg: shared types and constants of the accelerometer deadband filter
// Beat payloads, register indexes, reset values and lane configuration.
// ----------------------------------------------------------------------------
package adsf_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned PlayW   = 15;
  localparam int unsigned SensW   = 8;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OfsW    = 48;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_PLAY_RADIUS = 3'd0,
    REG_SENSITIVITY = 3'd1,
    REG_MODE        = 3'd2,
    REG_OFFSET_XYZ  = 3'd3,
    REG_ROW_X       = 3'd4,
    REG_ROW_Y       = 3'd5,
    REG_ROW_Z       = 3'd6
  } reg_idx_e;

  // Mode bits
  localparam int unsigned ModeOfsBit = 0;
  localparam int unsigned ModeRotBit = 1;

  // Reset values: unit gain, identity transform
  localparam logic [SensW-1:0] SensRst = 8'h80;
  localparam logic [CfgW-1:0]  RowXRst = 64'h0000_0000_0000_4000;
  localparam logic [CfgW-1:0]  RowYRst = 64'h0000_0000_4000_0000;
  localparam logic [CfgW-1:0]  RowZRst = 64'h0000_4000_0000_0000;

  typedef logic signed [DataW-1:0] sample_t;

  typedef struct packed {
    sample_t raw_z;
    sample_t raw_y;
    sample_t raw_x;
  } in_beat_t;

  typedef struct packed {
    sample_t out_z;
    sample_t out_y;
    sample_t out_x;
  } out_beat_t;

  // Tracking settings shared by all axis lanes
  typedef struct packed {
    logic [PlayW-1:0] play;
    logic [SensW-1:0] sens;
    logic             ofs_en;
  } trk_cfg_t;

endpackage
`default_nettype wire

FILE: hdl/adsf_axis_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adsf_axis_lane: one axis of the deadband tracking filter
// Holds the last filtered value, steps it on each accepted sample and
// presents it with the optional offset removed.
// ----------------------------------------------------------------------------
module adsf_axis_lane import adsf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire sample_t  raw_i,
  input  wire trk_cfg_t trk_cfg_i,
  input  wire sample_t  offset_i,
  output sample_t       val_o
);

  sample_t            last_q, last_d;
  logic signed [16:0] diff;
  logic signed [17:0] diff_x;
  logic signed [17:0] play_s;
  logic signed [17:0] excess;
  logic signed [8:0]  gain;
  logic signed [26:0] prod;

  assign diff   = 17'(raw_i) - 17'(last_q);
  assign diff_x = 18'(diff);
  assign play_s = signed'({3'b000, trk_cfg_i.play});
  assign gain   = signed'({1'b0, trk_cfg_i.sens});

  // Excess over the dead band; zero inside it, so the value holds
  always_comb begin
    if (diff_x < -play_s) begin
      excess = diff_x + play_s;
    end else if (diff_x > play_s) begin
      excess = diff_x - play_s;
    end else begin
      excess = '0;
    end
  end

  assign prod   = 27'(excess * gain);
  // Floor of prod / 128 is the arithmetic shift; wrap the sum to 16 bits
  assign last_d = last_q + sample_t'(prod[22:7]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (step_i) begin
      last_q <= last_d;
    end
  end

  assign val_o = trk_cfg_i.ofs_en ? sample_t'(last_q - offset_i) : last_q;

endmodule
`default_nettype wire

FILE: hdl/adsf_affine_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adsf_affine_row: one output row of the fixed-point affine transform
// Registers three Q2.14 products, then sums with the translation, truncates
// toward zero and saturates to 16 bits.
// ----------------------------------------------------------------------------
module adsf_affine_row import adsf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            load_i,
  input  wire logic [CfgW-1:0] row_i,
  input  wire sample_t         x_i,
  input  wire sample_t         y_i,
  input  wire sample_t         z_i,
  output sample_t              res_o
);

  logic signed [31:0] px_q, py_q, pz_q;
  sample_t            trans_q;
  logic signed [33:0] sum;
  logic signed [19:0] quot;
  logic signed [19:0] quot_tz;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      px_q    <= 32'(sample_t'(row_i[15:0])  * x_i);
      py_q    <= 32'(sample_t'(row_i[31:16]) * y_i);
      pz_q    <= 32'(sample_t'(row_i[47:32]) * z_i);
      trans_q <= sample_t'(row_i[63:48]);
    end
  end

  assign sum  = 34'(px_q) + 34'(py_q) + 34'(pz_q) + (34'(trans_q) <<< 14);
  assign quot = sum[33:14];

  // Round a negative quotient up when bits were shifted out
  assign quot_tz = (sum[33] && (sum[13:0] != '0)) ? quot + 20'sd1 : quot;

  always_comb begin
    if (quot_tz > 20'sd32767) begin
      res_o = 16'sh7fff;
    end else if (quot_tz < -20'sd32768) begin
      res_o = 16'sh8000;
    end else begin
      res_o = sample_t'(quot_tz[15:0]);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/accel_deadband_smoothing_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// accel_deadband_smoothing_filter_unit: three-axis accelerometer filter
// Deadband tracking per axis, optional offset removal, optional affine
// transform in Q2.14 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_i) takes one raw x, y, z
//   sample per beat. Output channel (out_valid_o / out_ready_i / out_o)
//   returns one filtered sample per input beat, in order.
//   Three axis lanes step their stored values in the accept cycle. The next
//   cycle forms each lane's offset-corrected value and loads the nine
//   transform products; the cycle after that sums each row into the output
//   register, as soon as that register is free or being read.
//   One sample is in flight at a time: in_ready_o stays low until the
//   sample has passed the product register and moved into the output
//   register, so the block takes no new beat before then.
//   A finished result waiting in the output register does not block the
//   next input beat. If the receiver stalls, the next result holds in the
//   product stage and input stays closed until the output register frees.
//   Reset clears the stored axis values to zero and loads the register
//   defaults: no dead band, unit gain, no offset, identity transform.
//   Write registers through cfg_we_i only while the block is idle.
// ----------------------------------------------------------------------------
module accel_deadband_smoothing_filter_unit import adsf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_beat_t           in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_beat_t               out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  // Configuration registers
  logic [PlayW-1:0] play_q;
  logic [SensW-1:0] sens_q;
  logic [ModeW-1:0] mode_q;
  logic [OfsW-1:0]  ofs_q;
  logic [CfgW-1:0]  row_x_q, row_y_q, row_z_q;

  // Pipeline control
  logic s1_q, s1_d;
  logic s2_q, s2_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic adv_out;

  trk_cfg_t  trk_cfg;
  sample_t   val_x, val_y, val_z;
  sample_t   byp_x_q, byp_y_q, byp_z_q;
  sample_t   rot_x, rot_y, rot_z;
  out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_q  <= '0;
      sens_q  <= SensRst;
      mode_q  <= '0;
      ofs_q   <= '0;
      row_x_q <= RowXRst;
      row_y_q <= RowYRst;
      row_z_q <= RowZRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PLAY_RADIUS: play_q  <= cfg_data_i[PlayW-1:0];
        REG_SENSITIVITY: sens_q  <= cfg_data_i[SensW-1:0];
        REG_MODE:        mode_q  <= cfg_data_i[ModeW-1:0];
        REG_OFFSET_XYZ:  ofs_q   <= cfg_data_i[OfsW-1:0];
        REG_ROW_X:       row_x_q <= cfg_data_i;
        REG_ROW_Y:       row_y_q <= cfg_data_i;
        REG_ROW_Z:       row_z_q <= cfg_data_i;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Open input only when no sample is in flight
  assign in_ready_o = !s1_q && !s2_q;
  assign accept     = in_valid_i && in_ready_o;
  // Move the product stage into the output register once it is free
  assign adv_out    = s2_q && (!out_valid_q || out_ready_i);

  assign s1_d        = accept;
  assign s2_d        = s1_q || (s2_q && !adv_out);
  assign out_valid_d = adv_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign trk_cfg.play   = play_q;
  assign trk_cfg.sens   = sens_q;
  assign trk_cfg.ofs_en = mode_q[ModeOfsBit];

  // Axis lanes
  adsf_axis_lane u_lane_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .raw_i     (in_i.raw_x),
    .trk_cfg_i (trk_cfg),
    .offset_i  (sample_t'(ofs_q[15:0])),
    .val_o     (val_x)
  );

  adsf_axis_lane u_lane_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .raw_i     (in_i.raw_y),
    .trk_cfg_i (trk_cfg),
    .offset_i  (sample_t'(ofs_q[31:16])),
    .val_o     (val_y)
  );

  adsf_axis_lane u_lane_z (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .raw_i     (in_i.raw_z),
    .trk_cfg_i (trk_cfg),
    .offset_i  (sample_t'(ofs_q[47:32])),
    .val_o     (val_z)
  );

  // Merge: each transform row combines all three lanes
  adsf_affine_row u_row_x (
    .clk_i  (clk_i),
    .load_i (s1_q),
    .row_i  (row_x_q),
    .x_i    (val_x),
    .y_i    (val_y),
    .z_i    (val_z),
    .res_o  (rot_x)
  );

  adsf_affine_row u_row_y (
    .clk_i  (clk_i),
    .load_i (s1_q),
    .row_i  (row_y_q),
    .x_i    (val_x),
    .y_i    (val_y),
    .z_i    (val_z),
    .res_o  (rot_y)
  );

  adsf_affine_row u_row_z (
    .clk_i  (clk_i),
    .load_i (s1_q),
    .row_i  (row_z_q),
    .x_i    (val_x),
    .y_i    (val_y),
    .z_i    (val_z),
    .res_o  (rot_z)
  );

  // Hold the untransformed values beside the products
  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      byp_x_q <= val_x;
      byp_y_q <= val_y;
      byp_z_q <= val_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      if (mode_q[ModeRotBit]) begin
        out_q.out_x <= rot_x;
        out_q.out_y <= rot_y;
        out_q.out_z <= rot_z;
      end else begin
        out_q.out_x <= byp_x_q;
        out_q.out_y <= byp_y_q;
        out_q.out_z <= byp_z_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

FILE: hdl/adsf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adsf_checker: port-level checks for the deadband filter
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module adsf_checker import adsf_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire out_beat_t          out_o
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output beat changed while stalled");

  // After an input beat, input stays closed while the sample is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input reopened while a sample was in flight");

  // A new result only appears when a sample was being processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result beat without a sample in flight");

  // A result is taken or held, never dropped, while input is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !in_ready_o |=> out_valid_o)
    else $error("pending result beat lost");

endmodule

bind accel_deadband_smoothing_filter_unit adsf_checker u_adsf_checker (.*);
`default_nettype wire
